// File: rtl/core/swc_pkg.sv
// Shared constants and types for the subtract-with-carry generator.
package swc_pkg;

    // Generator geometry
    localparam int WORD_BITS = 24;
    localparam int NEAR_LAG  = 10;
    localparam int FAR_LAG   = 24;
    localparam int STEP_BITS = $clog2(FAR_LAG);

    // Cell that holds x(i - NEAR_LAG) when cell 0 holds x(i - FAR_LAG)
    localparam int TAP_SHORT = (FAR_LAG - (NEAR_LAG % FAR_LAG)) % FAR_LAG;

    // Congruential seeding generator: x = (LCG_MUL * x) mod LCG_MOD
    localparam int LCG_MUL_BITS = 16;
    localparam int PROD_BITS    = LCG_MUL_BITS + 32;
    localparam int FOLD_SHIFT   = 31;
    localparam logic [LCG_MUL_BITS-1:0] LCG_MUL   = 16'd40014;
    localparam logic [31:0]             LCG_MOD   = 32'd2147483563;
    localparam logic [31:0]             LCG_RESET = 32'd19780503;
    // 2^31 mod LCG_MOD
    localparam logic [7:0]              LCG_FOLD  = 8'd85;

    // Scaling
    localparam int SCALE_BITS = 8;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 8'd255;

    // Item modes
    localparam logic MODE_RESEED = 1'b0;
    localparam logic MODE_DRAW   = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

    // Status of the seeding sequencer as seen by the top level
    typedef struct packed {
        logic busy;
        logic step_valid;
        logic last_step;
    } lcg_status_t;

endpackage

// File: rtl/core/swc_cell.sv
// One history cell: holds a word and takes its neighbor's word on a shift.
module swc_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift_en,
    input  swc_pkg::word_t word_in,
    output swc_pkg::word_t word_out
);
    import swc_pkg::*;

    word_t word_reg;
    word_t word_next;

    // Take the neighbor's word on a shift, hold otherwise
    always_comb
    begin
        word_next = shift_en ? word_in : word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

// File: rtl/core/swc_lcg.sv
// Seeding sequencer: FAR_LAG congruential steps, each a multiply then a reduce.
module swc_lcg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          seed,
    output swc_pkg::lcg_status_t status,
    output swc_pkg::word_t       step_word
);
    import swc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic [31:0]          lcg_reg, lcg_next;
    logic [PROD_BITS-1:0] prod_reg, prod_next;

    logic [PROD_BITS-FOLD_SHIFT-1:0] prod_hi;
    logic [31:0]                     folded;
    logic [31:0]                     reduced;
    logic                            last;

    // Fold the high part back in: 2^31 is congruent to LCG_FOLD
    always_comb
    begin
        prod_hi = prod_reg[PROD_BITS-1:FOLD_SHIFT];
        folded  = {1'b0, prod_reg[FOLD_SHIFT-1:0]}
                + (32'(prod_hi) * 32'(LCG_FOLD));
        reduced = (folded >= LCG_MOD) ? (folded - LCG_MOD) : folded;
        last    = (cnt_reg == STEP_BITS'(FAR_LAG - 1));
    end

    // Sequence multiply and reduce for each step
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lcg_next   = lcg_reg;
        prod_next  = prod_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    lcg_next   = seed;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_BITS'(LCG_MUL) * PROD_BITS'(lcg_reg);
                state_next = ST_RED;
            end
            ST_RED:
            begin
                lcg_next = reduced;
                if (last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            lcg_reg   <= LCG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lcg_reg   <= lcg_next;
        end
    end

    // Product needs no reset
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign status.busy       = (state_reg != ST_IDLE);
    assign status.step_valid = (state_reg == ST_RED);
    assign status.last_step  = (state_reg == ST_RED) && last;
    assign step_word         = reduced[WORD_BITS-1:0];

    property p_cnt_range;
        @(posedge clk) disable iff (!rst_n)
        cnt_reg <= STEP_BITS'(FAR_LAG - 1);
    endproperty
    a_cnt_range: assert property (p_cnt_range)
        else $error("seed step counter out of range");

    property p_reduced_range;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RED) |-> (reduced < LCG_MOD);
    endproperty
    a_reduced_range: assert property (p_reduced_range)
        else $error("congruential step not fully reduced");

    property p_start_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> (state_reg == ST_MUL);
    endproperty
    a_start_busy: assert property (p_start_busy)
        else $error("seeding did not start");

endmodule

// File: rtl/core/subtract_with_carry_rng_unit.sv
// Top level: subtract-with-carry generator with shift-line history and scaling.
// Draw beat: one per cycle when not stalled; draw stage, then output register.
// Reseed beat: stall held after the accepting edge while the sequencer runs
//   FAR_LAG congruential steps, one multiply and one reduce per step.
// Output register and draw stage let a draw enter while a result waits.
// Reset (asynchronous): history zero, borrow clear, scale_limit 255, no result.
module subtract_with_carry_rng_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                mode,
    input  logic [31:0]                         seed_value,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [swc_pkg::WORD_BITS-1:0]       raw_word,
    output logic [swc_pkg::SCALE_BITS-1:0]      scaled_value,
    input  logic                                cfg_write_en,
    input  logic [swc_pkg::SCALE_BITS-1:0]      cfg_write_data
);
    import swc_pkg::*;

    lcg_status_t lcg_status;
    word_t       lcg_word;

    word_t cell_word [FAR_LAG];
    word_t cell_in   [FAR_LAG];

    logic item_acc, draw_acc, reseed_acc;
    logic shift_en;
    word_t new_word;
    logic [WORD_BITS:0] diff;

    logic borrow_reg, borrow_next;
    logic [SCALE_BITS-1:0] scale_reg;

    logic  s1_valid_reg, s1_valid_next;
    word_t s1_raw_reg, s1_raw_next;
    logic  s1_adv, out_load;

    logic  result_valid_reg, result_valid_next;
    word_t raw_reg, raw_next;
    logic [SCALE_BITS-1:0] scaled_reg, scaled_next;
    logic [WORD_BITS+SCALE_BITS:0] scale_prod;

    // Accept beats
    assign out_load   = !result_valid_reg || !result_stall;
    assign s1_adv     = s1_valid_reg && out_load;
    assign item_stall = lcg_status.busy || (s1_valid_reg && !s1_adv);
    assign item_acc   = item_valid && !item_stall;
    assign draw_acc   = item_acc && (mode == MODE_DRAW);
    assign reseed_acc = item_acc && (mode == MODE_RESEED);

    swc_lcg u_lcg (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (reseed_acc),
        .seed      (seed_value),
        .status    (lcg_status),
        .step_word (lcg_word)
    );

    // Subtract with borrow: x(i-NEAR_LAG) - x(i-FAR_LAG) - borrow
    always_comb
    begin
        diff = {1'b0, cell_word[TAP_SHORT]} - {1'b0, cell_word[0]}
             - {{WORD_BITS{1'b0}}, borrow_reg};
    end

    assign shift_en = draw_acc || lcg_status.step_valid;
    assign new_word = lcg_status.step_valid ? lcg_word : diff[WORD_BITS-1:0];

    // History shift line: oldest word in cell 0, newest enters at the top
    genvar gi;
    generate
        for (gi = 0; gi < FAR_LAG; gi++)
        begin : g_cell
            if (gi == FAR_LAG - 1)
            begin : g_top
                assign cell_in[gi] = new_word;
            end
            else
            begin : g_mid
                assign cell_in[gi] = cell_word[gi+1];
            end
            swc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .word_in  (cell_in[gi]),
                .word_out (cell_word[gi])
            );
        end
    endgenerate

    // Update borrow on a draw, set it from the last seed word
    always_comb
    begin
        borrow_next = borrow_reg;
        if (lcg_status.last_step)
        begin
            borrow_next = (lcg_word == '0);
        end
        else if (draw_acc)
        begin
            borrow_next = diff[WORD_BITS];
        end
    end

    // Advance draw stage and output register
    always_comb
    begin
        s1_raw_next = draw_acc ? diff[WORD_BITS-1:0] : s1_raw_reg;
        if (draw_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        scale_prod = s1_raw_reg * ({1'b0, scale_reg} + 1'b1);
        result_valid_next = out_load ? s1_valid_reg : result_valid_reg;
        raw_next          = s1_adv ? s1_raw_reg : raw_reg;
        scaled_next       = s1_adv ? scale_prod[WORD_BITS+SCALE_BITS-1:WORD_BITS]
                                   : scaled_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            borrow_reg       <= 1'b0;
            scale_reg        <= SCALE_RESET;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            borrow_reg       <= borrow_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write_en)
            begin
                scale_reg <= cfg_write_data;
            end
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge clk)
    begin
        s1_raw_reg <= s1_raw_next;
        raw_reg    <= raw_next;
        scaled_reg <= scaled_next;
    end

    assign result_valid = result_valid_reg;
    assign raw_word     = raw_reg;
    assign scaled_value = scaled_reg;

    property p_busy_stalls;
        @(posedge clk) disable iff (!rst_n)
        lcg_status.busy |-> item_stall;
    endproperty
    a_busy_stalls: assert property (p_busy_stalls)
        else $error("beat taken while seeding");

    property p_reseed_busy;
        @(posedge clk) disable iff (!rst_n)
        reseed_acc |=> lcg_status.busy && !result_valid_reg || lcg_status.busy;
    endproperty
    a_reseed_busy: assert property (p_reseed_busy)
        else $error("reseed beat did not start seeding");

    property p_draw_no_seed_clash;
        @(posedge clk) disable iff (!rst_n)
        lcg_status.step_valid |-> !draw_acc;
    endproperty
    a_draw_no_seed_clash: assert property (p_draw_no_seed_clash)
        else $error("draw and seed step shift together");

    property p_s1_holds;
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> s1_valid_reg && $stable(s1_raw_reg);
    endproperty
    a_s1_holds: assert property (p_s1_holds)
        else $error("draw stage lost its word");

endmodule

// File: bench/subtract_with_carry_rng_unit_tb.sv
// Self-checking bench for the subtract-with-carry generator: directed table, random beats.
module subtract_with_carry_rng_unit_tb;
    import swc_pkg::*;

    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 11;
    localparam int          SEEDING_SLACK = 2 * FAR_LAG + 8;
    localparam int          BEATS_PER_PHASE = 262;
    localparam int          PHASES        = 4;
    localparam int          DIR_ROWS      = 25;
    localparam longint      WATCHDOG_TIME = 64'd9_600_000;
    localparam logic [31:0] TWICE_MOD     = LCG_MOD << 1;
    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
    localparam word_t       WORD_MAX      = {WORD_BITS{1'b1}};

    typedef logic [SCALE_BITS-1:0] scale_t;

    typedef struct packed {
        word_t  raw;
        scale_t scaled;
    } draw_t;

    typedef struct packed {
        logic        m;
        logic [31:0] seed;
        logic        typed;
        word_t       raw;
        scale_t      scaled;
    } dir_row_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        item_valid     = 1'b0;
    logic        item_stall;
    logic        mode           = MODE_DRAW;
    logic [31:0] seed_value     = '0;
    logic        result_valid;
    logic        result_stall   = 1'b0;
    word_t       raw_word;
    scale_t      scaled_value;
    logic        cfg_write_en   = 1'b0;
    scale_t      cfg_write_data = '0;

    // Generator image kept by the bench
    word_t       swc_cells [FAR_LAG];
    logic        swc_borrow;
    int          swc_pos;
    logic [31:0] lcg_word;
    scale_t      scale_cap;

    draw_t       pending_draws [$];
    int          fault_count = 0;
    int          gap_pct     = 0;
    int          stall_pct   = 0;

    // Directed beats: typed results only where they are obvious
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{MODE_DRAW,   32'd0,      1'b1, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b1, 24'h000000, 8'd0},
        '{MODE_RESEED, 32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b1, WORD_MAX,   8'd255},
        '{MODE_DRAW,   32'd0,      1'b1, WORD_MAX,   8'd255},
        '{MODE_RESEED, LCG_MOD,    1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b1, WORD_MAX,   8'd255},
        '{MODE_RESEED, TWICE_MOD,  1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   ALL_ONES,   1'b1, WORD_MAX,   8'd255},
        '{MODE_RESEED, ALL_ONES,   1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   ALL_ONES,   1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_RESEED, 32'd1,      1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_RESEED, LCG_RESET,  1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_RESEED, LCG_MOD - 1, 1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0},
        '{MODE_DRAW,   32'd0,      1'b0, 24'h000000, 8'd0}
    };

    int     phase_gap   [PHASES] = '{0, 68, 0, 26};
    int     phase_stall [PHASES] = '{0, 0, 68, 26};
    scale_t phase_limit [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd0};

    subtract_with_carry_rng_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .mode           (mode),
        .seed_value     (seed_value),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .raw_word       (raw_word),
        .scaled_value   (scaled_value),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // One congruential seeding step, exact in 64 bits
    function automatic logic [31:0] congruential_step(input logic [31:0] x);
        logic [63:0] prod;
        prod = 64'(LCG_MUL) * 64'(x);
        return 32'(prod % 64'(LCG_MOD));
    endfunction

    // Refill the history from a seed
    task automatic load_seed(input logic [31:0] s);
        lcg_word = s;
        for (int k = 0; k < FAR_LAG; k++)
        begin
            lcg_word     = congruential_step(lcg_word);
            swc_cells[k] = lcg_word[WORD_BITS-1:0];
        end
        swc_borrow = (swc_cells[FAR_LAG-1] == '0);
        swc_pos    = 0;
    endtask

    // Produce the next word and its scaled value, then advance the ring
    task automatic next_swc_word(output draw_t r);
        int              p;
        int              ps;
        logic [WORD_BITS:0] diff;
        logic [32:0]     prod;
        p    = swc_pos;
        ps   = (p + FAR_LAG - (NEAR_LAG % FAR_LAG)) % FAR_LAG;
        diff = {1'b0, swc_cells[ps]} - {1'b0, swc_cells[p]} - {{WORD_BITS{1'b0}}, swc_borrow};
        swc_borrow   = diff[WORD_BITS];
        swc_cells[p] = diff[WORD_BITS-1:0];
        swc_pos      = (p + 1 >= FAR_LAG) ? 0 : p + 1;
        prod     = 33'(diff[WORD_BITS-1:0]) * (33'(scale_cap) + 33'd1);
        r.raw    = diff[WORD_BITS-1:0];
        r.scaled = prod[WORD_BITS+SCALE_BITS-1:WORD_BITS];
    endtask

    // Offer one beat; enter with time at a rising edge, leave at the accepting edge
    task automatic send_beat(input logic m, input logic [31:0] s, input logic typed,
                             input draw_t typed_res);
        draw_t predicted;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        mode       <= m;
        seed_value <= s;
        do
            @(negedge clk);
        while (item_stall);
        if (m == MODE_DRAW)
        begin
            next_swc_word(predicted);
            pending_draws.push_back(typed ? typed_res : predicted);
        end
        else
        begin
            load_seed(s);
        end
        @(posedge clk);
    endtask

    // Hold the sender until every expected draw has come back
    task automatic drain_draws();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_draws.size() != 0);
    endtask

    task automatic write_scale_limit(input scale_t v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        scale_cap = v;
    endtask

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(11))
            0:       return 32'd0;
            1:       return LCG_MOD;
            2:       return TWICE_MOD;
            3:       return ALL_ONES;
            4:       return LCG_MOD - 1;
            default: return $urandom;
        endcase
    endfunction

    // Random receiver stall
    always @(posedge clk)
        result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Compare each accepted result beat with the oldest expectation
    initial
    begin
        logic  take;
        draw_t got;
        draw_t want;
        forever
        begin
            @(negedge clk);
            take = rst_n && result_valid && !result_stall;
            got  = '{raw_word, scaled_value};
            @(posedge clk);
            if (take)
            begin
                if (pending_draws.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: unexpected result, expected none, got raw %h scaled %0d",
                             $time, got.raw, got.scaled);
                end
                else
                begin
                    want = pending_draws.pop_front();
                    if (got.raw !== want.raw)
                    begin
                        fault_count++;
                        $display("%0t: raw_word expected %h got %h",
                                 $time, want.raw, got.raw);
                    end
                    if (got.scaled !== want.scaled)
                    begin
                        fault_count++;
                        $display("%0t: scaled_value expected %0d got %0d",
                                 $time, want.scaled, got.scaled);
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [31:0] s;
        scale_t      lim;
        foreach (swc_cells[k])
            swc_cells[k] = '0;
        swc_borrow = 1'b0;
        swc_pos    = 0;
        lcg_word   = LCG_RESET;
        scale_cap  = SCALE_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table under the reset scale limit
        foreach (directed_rows[i])
            send_beat(directed_rows[i].m, directed_rows[i].seed, directed_rows[i].typed,
                      '{directed_rows[i].raw, directed_rows[i].scaled});

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // Let the block settle, including a seeding run, before the register write
            drain_draws();
            repeat (SEEDING_SLACK) @(posedge clk);
            lim = (ph == PHASES - 1) ? scale_t'($urandom_range(254, 2)) : phase_limit[ph];
            write_scale_limit(lim);
            gap_pct   = phase_gap[ph];
            stall_pct = phase_stall[ph];

            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                if (n == BEATS_PER_PHASE / 2)
                    drain_draws();
                if ($urandom_range(99) < 5)
                begin
                    s = pick_seed();
                    send_beat(MODE_RESEED, s, 1'b0, '0);
                end
                else
                begin
                    send_beat(MODE_DRAW, $urandom, 1'b0, '0);
                end
            end
        end

        // Wind down and give the verdict
        drain_draws();
        repeat (SEEDING_SLACK) @(posedge clk);
        if (fault_count == 0 && pending_draws.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #WATCHDOG_TIME;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
